// ----- hdl/fixed_point_line_rasterizer_macros.svh -----
// Assertion helpers used by the rasterizer RTL.
// Every check is sampled on the rising edge of i_clk and is ignored in reset.
`ifndef FIXED_POINT_LINE_RASTERIZER_MACROS_SVH
`define FIXED_POINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication check.
`define FPLR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define FPLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fplr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fplr_pkg
// Shared types and codes for the fixed-point line rasterizer.
// ----------------------------------------------------------------------------
package fplr_pkg;

    // operation codes on the input channel
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // divider sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // divider status toward the top level
    typedef struct packed {
        logic busy;   // iterations in progress
        logic done;   // final quotient bit this cycle
    } t_div_stat;

endpackage
`default_nettype wire

// ----- hdl/fplr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fplr_div
// Restoring divider for the minor-axis step: (num << FRAC_BITS) / den,
// one quotient bit per cycle through a single subtract-and-compare unit.
// Requires num <= den, so the quotient fits in FRAC_BITS + 1 bits.
// ----------------------------------------------------------------------------
module fplr_div
    import fplr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [COORD_BITS:0]    i_num,
    input  wire logic [COORD_BITS:0]    i_den,
    output t_div_stat                   o_stat,
    output logic      [FRAC_BITS:0]     o_quot
);

    localparam int REM_W = COORD_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    t_state                r_state;
    logic [REM_W-1:0]      r_rem;
    logic [COORD_BITS:0]   r_den;
    logic [FRAC_BITS-1:0]  r_q;
    logic [CNT_W-1:0]      r_cnt;

    logic                  ge;
    logic [REM_W-1:0]      diff;
    logic [REM_W-1:0]      kept;

    // shared compare / subtract unit
    assign diff = r_rem - {1'b0, r_den};
    assign ge   = (r_rem >= {1'b0, r_den});
    assign kept = ge ? diff : r_rem;

    assign o_stat.busy = (r_state == ST_RUN);
    assign o_stat.done = (r_state == ST_RUN) && (r_cnt == '0);
    assign o_quot      = {r_q, ge};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_cnt   <= CNT_W'(FRAC_BITS);
                    end
                end
                ST_RUN: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath: first bit compares num itself, later bits the doubled remainder
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == ST_IDLE)) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_state == ST_RUN) begin
            r_rem <= {kept[REM_W-2:0], 1'b0};
            r_q   <= {r_q[FRAC_BITS-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fixed_point_line_rasterizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Start: once accepted, the minor step is computed in the serial divider
//   (one quotient bit per cycle); ready stays low while the divider is busy.
// Step: one per cycle while ready is high, the pixel in the output register
//   next cycle; a new item is taken while a pixel waits if the sink is ready.
// Reset (synchronous, active low): no line in progress, output empty,
//   row_pitch back to 640.
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer
// DDA line rasterizer with fixed-point accumulators. A start loads the
// endpoints and computes the minor step; each step within a line emits one pixel address.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer
    import fplr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_wr_en,
    input  wire logic [COORD_BITS:0]       i_wr_data,
    // input channel
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_operation,
    input  wire logic [COORD_BITS-1:0]     i_x_start,
    input  wire logic [COORD_BITS-1:0]     i_y_start,
    input  wire logic [COORD_BITS-1:0]     i_x_end,
    input  wire logic [COORD_BITS-1:0]     i_y_end,
    input  wire logic [7:0]                i_color,
    // output channel
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [2*COORD_BITS-1:0]        o_pixel_address,
    output logic [7:0]                     o_pixel_color,
    output logic                           o_last_pixel,
    output logic                           o_off_screen
);

`include "fixed_point_line_rasterizer_macros.svh"

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int LEFT_W = COORD_BITS + 1;
    localparam int ADDR_W = 2 * COORD_BITS;
    localparam int PROD_W = 2 * COORD_BITS + 1;
    localparam int PIX_W  = COORD_BITS + 2;
    localparam logic [INC_W-1:0] ONE_STEP = INC_W'(1) << FRAC_BITS;
    localparam logic [COORD_BITS:0] PITCH_RESET = LEFT_W'(640);

    // state
    logic [COORD_BITS:0]   r_pitch;
    logic [ACC_W-1:0]      r_xacc;
    logic [ACC_W-1:0]      r_yacc;
    logic [INC_W-1:0]      r_xinc;
    logic [INC_W-1:0]      r_yinc;
    logic [LEFT_W-1:0]     r_left;
    logic [7:0]            r_color;
    logic                  r_minor_x;
    logic                  r_neg;
    logic                  r_valid;
    logic [ADDR_W-1:0]     r_addr;
    logic [7:0]            r_out_color;
    logic                  r_last;
    logic                  r_off;

    t_div_stat             div_stat;
    logic [FRAC_BITS:0]    div_quot;

    logic                  in_fire;
    logic                  start_fire;
    logic                  step_fire;

    // start decode
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  major_x;
    logic [LEFT_W-1:0]     len;
    logic [COORD_BITS-1:0] mfrom;
    logic [COORD_BITS-1:0] mto;
    logic [LEFT_W-1:0]     mdelta;
    logic [INC_W-1:0]      quot_ext;
    logic [INC_W-1:0]      minor_inc;

    // step datapath
    logic [PIX_W-1:0]      px_full;
    logic [PIX_W-1:0]      py_full;
    logic                  off;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     addr_sum;

    // handshake
    assign o_ready    = !div_stat.busy && (!r_valid || i_ready);
    assign in_fire    = i_valid && o_ready;
    assign start_fire = in_fire && (i_operation == OP_START);
    assign step_fire  = in_fire && (i_operation == OP_STEP) && (r_left != '0);

    // spans, major axis and minor delta magnitude
    assign adx     = (i_x_end >= i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign ady     = (i_y_end >= i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
    assign major_x = (adx >= ady);
    assign len     = {1'b0, (major_x ? adx : ady)} + 1'b1;
    assign mfrom   = major_x ? i_y_start : i_x_start;
    assign mto     = major_x ? i_y_end : i_x_end;
    assign mdelta  = {1'b0, (major_x ? ady : adx)} + 1'b1;

    // quotient back to a signed step, truncated toward zero
    assign quot_ext  = {1'b0, div_quot};
    assign minor_inc = r_neg ? -quot_ext : quot_ext;

    fplr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_fire),
        .i_num   (mdelta),
        .i_den   (len),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // floor of the accumulators and screen test
    assign px_full  = r_xacc[ACC_W-1:FRAC_BITS];
    assign py_full  = r_yacc[ACC_W-1:FRAC_BITS];
    assign off      = px_full[PIX_W-1] || px_full[COORD_BITS] ||
                      py_full[PIX_W-1] || py_full[COORD_BITS];
    assign prod     = PROD_W'(py_full[COORD_BITS-1:0]) * PROD_W'(r_pitch);
    assign addr_sum = prod + {{(PROD_W-COORD_BITS){1'b0}}, px_full[COORD_BITS-1:0]};

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= PITCH_RESET;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_pitch <= i_wr_data;
            end
            if (start_fire) begin
                r_left <= len;
            end else if (step_fire) begin
                r_left <= r_left - 1'b1;
            end
            if (step_fire) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // line setup and accumulator stepping
    always_ff @(posedge i_clk) begin
        if (start_fire) begin
            r_xacc    <= {2'b00, i_x_start, {FRAC_BITS{1'b0}}};
            r_yacc    <= {2'b00, i_y_start, {FRAC_BITS{1'b0}}};
            r_color   <= i_color;
            r_minor_x <= !major_x;
            r_neg     <= (mfrom > mto);
            if (major_x) begin
                r_xinc <= (i_x_start > i_x_end) ? -ONE_STEP : ONE_STEP;
            end else begin
                r_yinc <= (i_y_start > i_y_end) ? -ONE_STEP : ONE_STEP;
            end
        end else if (div_stat.done) begin
            if (r_minor_x) begin
                r_xinc <= minor_inc;
            end else begin
                r_yinc <= minor_inc;
            end
        end else if (step_fire) begin
            r_xacc <= r_xacc + {{(ACC_W-INC_W){r_xinc[INC_W-1]}}, r_xinc};
            r_yacc <= r_yacc + {{(ACC_W-INC_W){r_yinc[INC_W-1]}}, r_yinc};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_addr      <= off ? '0 : addr_sum[ADDR_W-1:0];
            r_out_color <= r_color;
            r_last      <= (r_left == LEFT_W'(1));
            r_off       <= off;
        end
    end

    assign o_valid         = r_valid;
    assign o_pixel_address = r_addr;
    assign o_pixel_color   = r_out_color;
    assign o_last_pixel    = r_last;
    assign o_off_screen    = r_off;

    // checks
    `FPLR_ASSERT_IMPL(a_no_accept_busy, div_stat.busy, !o_ready, "item taken during division")
    `FPLR_ASSERT_NEXT(a_last_flag, step_fire && (r_left == LEFT_W'(1)),
        o_valid && o_last_pixel && (r_left == '0), "last pixel not flagged")
    `FPLR_ASSERT_IMPL(a_off_addr, o_valid && o_off_screen, o_pixel_address == '0,
        "off-screen pixel with nonzero address")
    `FPLR_ASSERT_NEXT(a_start_busy, start_fire, div_stat.busy, "divider not started")

endmodule
`default_nettype wire

// ----- dv/tb_fixed_point_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_line_rasterizer
// Self-checking bench for the DDA line rasterizer. Line starts and pixel
// steps are queued, driven over the input channel and tracked by an
// in-bench pixel predictor. Each pixel transfer on the output channel is
// checked field by field against the oldest predicted pixel. Phases change
// the row pitch (extremes included) and the idle/stall pattern on both sides.
// ----------------------------------------------------------------------------
module tb_fixed_point_line_rasterizer;
    import fplr_pkg::*;

    localparam int COORD_BITS      = 10;
    localparam int FRAC_BITS       = 10;
    localparam longint ONE_PIXEL   = longint'(1) << FRAC_BITS;
    localparam longint COORD_MAX   = (longint'(1) << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES   = 2 * FRAC_BITS + 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 8;

    typedef struct {
        logic                  op;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic [7:0]            col;
    } line_item_t;

    typedef struct {
        logic [2*COORD_BITS-1:0] addr;
        logic [7:0]              col;
        logic                    last;
        logic                    off;
    } pixel_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_wr_en = 1'b0;
    logic [COORD_BITS:0]     i_wr_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_operation = OP_STEP;
    logic [COORD_BITS-1:0]   i_x_start = '0;
    logic [COORD_BITS-1:0]   i_y_start = '0;
    logic [COORD_BITS-1:0]   i_x_end = '0;
    logic [COORD_BITS-1:0]   i_y_end = '0;
    logic [7:0]              i_color = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [2*COORD_BITS-1:0] o_pixel_address;
    logic [7:0]              o_pixel_color;
    logic                    o_last_pixel;
    logic                    o_off_screen;

    fixed_point_line_rasterizer #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (i_wr_en),
        .i_wr_data       (i_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .i_color         (i_color),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel),
        .o_off_screen    (o_off_screen)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    line_item_t item_q[$];          // items waiting to be driven
    line_item_t held_item;          // item currently on the input port
    pixel_t     pixel_expect_q[$];  // predicted pixels, oldest first
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // predictor state
    logic [COORD_BITS:0] row_pitch_m = 11'd640;
    longint              x_acc = 0;
    longint              y_acc = 0;
    longint              x_inc = 0;
    longint              y_inc = 0;
    longint              pix_left = 0;
    logic [7:0]          line_col = '0;

    // minor axis step: (delta +/- 1) in fixed point over the line length,
    // truncated toward zero
    function automatic longint minor_inc(input longint a, input longint b,
                                         input longint span);
        longint d;
        d = (a <= b) ? (b - a + 1) : (b - a - 1);
        return (d * ONE_PIXEL) / span;
    endfunction

    // advance the predicted rasterizer by one accepted item
    task automatic rasterize_item(input line_item_t it);
        longint x0, y0, x1, y1, adx, ady, span, px, py;
        pixel_t pix;
        if (it.op == OP_START) begin
            x0 = longint'(it.xs);
            y0 = longint'(it.ys);
            x1 = longint'(it.xe);
            y1 = longint'(it.ye);
            adx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
            ady = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
            x_acc = x0 * ONE_PIXEL;
            y_acc = y0 * ONE_PIXEL;
            if (adx >= ady) begin
                span  = adx + 1;
                x_inc = (x0 > x1) ? -ONE_PIXEL : ONE_PIXEL;
                y_inc = minor_inc(y0, y1, span);
            end else begin
                span  = ady + 1;
                y_inc = (y0 > y1) ? -ONE_PIXEL : ONE_PIXEL;
                x_inc = minor_inc(x0, x1, span);
            end
            pix_left = span;
            line_col = it.col;
        end else if (pix_left != 0) begin
            // floor of the fixed-point position
            px = x_acc >>> FRAC_BITS;
            py = y_acc >>> FRAC_BITS;
            pix.off  = (px < 0) || (py < 0) || (px > COORD_MAX) || (py > COORD_MAX);
            pix.addr = pix.off ? '0 : (2*COORD_BITS)'(py * longint'(row_pitch_m) + px);
            pix.col  = line_col;
            x_acc    = x_acc + x_inc;
            y_acc    = y_acc + y_inc;
            pix_left = pix_left - 1;
            pix.last = (pix_left == 0);
            pixel_expect_q.push_back(pix);
        end
    endtask

    function automatic void compare_pixel_field(input string what, input longint want,
                                                input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // input channel driver
    always @(posedge i_clk) begin : drive_proc
        line_item_t nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                rasterize_item(held_item);
            if (!i_valid || o_ready) begin
                if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = item_q.pop_front();
                    held_item = nxt;
                    i_valid     <= 1'b1;
                    i_operation <= nxt.op;
                    i_x_start   <= nxt.xs;
                    i_y_start   <= nxt.ys;
                    i_x_end     <= nxt.xe;
                    i_y_end     <= nxt.ye;
                    i_color     <= nxt.col;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output channel monitor and sink
    always @(posedge i_clk) begin : watch_proc
        pixel_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pixel_expect_q.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual addr %0d color %0d",
                             $time, o_pixel_address, o_pixel_color);
                    errors++;
                end else begin
                    want = pixel_expect_q.pop_front();
                    compare_pixel_field("pixel_address", longint'(want.addr),
                                        longint'(o_pixel_address));
                    compare_pixel_field("pixel_color", longint'(want.col),
                                        longint'(o_pixel_color));
                    compare_pixel_field("last_pixel", longint'(want.last),
                                        longint'(o_last_pixel));
                    compare_pixel_field("off_screen", longint'(want.off),
                                        longint'(o_off_screen));
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(input logic op, input int xs, input int ys, input int xe,
                              input int ye, input int col);
        line_item_t it;
        it.op  = op;
        it.xs  = COORD_BITS'(xs);
        it.ys  = COORD_BITS'(ys);
        it.xe  = COORD_BITS'(xe);
        it.ye  = COORD_BITS'(ye);
        it.col = 8'(col);
        item_q.push_back(it);
    endtask

    // step items; endpoint fields are don't-care and get random content
    task automatic queue_steps(input int n);
        repeat (n)
            queue_item(OP_STEP, $urandom_range(1023), $urandom_range(1023),
                       $urandom_range(1023), $urandom_range(1023), $urandom_range(255));
    endtask

    // coordinate biased toward the edges of the screen
    function automatic int pick_coord();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return $urandom_range(1023, 1020);
            default: return $urandom_range(1023);
        endcase
    endfunction

    function automatic int near_coord(input int c);
        int v;
        v = c + $urandom_range(24) - 12;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v;
    endfunction

    // random line start; mostly short lines, rarely one with independently chosen endpoints
    task automatic queue_start(output int span);
        int x0, y0, x1, y1, adx, ady;
        x0 = pick_coord();
        y0 = pick_coord();
        if ($urandom_range(63) == 0) begin
            x1 = pick_coord();
            y1 = pick_coord();
        end else begin
            x1 = near_coord(x0);
            y1 = near_coord(y0);
        end
        adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
        span = ((adx >= ady) ? adx : ady) + 1;
        queue_item(OP_START, x0, y0, x1, y1, $urandom_range(255));
    endtask

    // wait until every item is in and every pixel is out, then let a
    // pending start finish in the divider
    task automatic drain();
        do @(negedge i_clk);
        while (item_q.size() != 0 || i_valid || pixel_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_row_pitch(input logic [COORD_BITS:0] v);
        drain();
        @(posedge i_clk);
        i_wr_en     <= 1'b1;
        i_wr_data   <= v;
        row_pitch_m = v;
        @(posedge i_clk);
        i_wr_en <= 1'b0;
    endtask

    // run limit
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [COORD_BITS:0] pitch_list [NUM_PHASES];
        int ph, made, kind, span, n;

        pitch_list = '{11'd1, 11'd1024, 11'd0, 11'd2047,
                       11'($urandom_range(1024, 1)), 11'd640,
                       11'($urandom_range(2047)), 11'd3};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: step while idle, nothing should come out
        queue_steps(1);
        // shallow line whose minor axis overshoots below y = 0
        queue_item(OP_START, 0, 1, 3, 0, 0);
        queue_steps(4);
        // full-range diagonal, cut short by the next start
        queue_item(OP_START, 1023, 1023, 0, 0, 255);
        queue_steps(2);
        // single-pixel line followed by an ignored step
        queue_item(OP_START, 0, 0, 0, 0, 8'hA5);
        queue_steps(2);
        // steep line whose minor axis overshoots below x = 0
        queue_item(OP_START, 1, 0, 0, 3, 8'h5A);
        queue_steps(4);
        // right edge of the bottom row
        queue_item(OP_START, 1020, 1023, 1023, 1023, 8'h3C);
        queue_steps(4);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_row_pitch(pitch_list[ph]);
            @(negedge i_clk);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            made = 0;
            while (made < ITEMS_PER_PHASE) begin
                kind = $urandom_range(99);
                if (kind < 8) begin
                    // noise: any operation with any content
                    queue_item(1'($urandom_range(1)), $urandom_range(1023),
                               $urandom_range(1023), $urandom_range(1023),
                               $urandom_range(1023), $urandom_range(255));
                    made++;
                end else begin
                    queue_start(span);
                    // some lines are abandoned early, the rest run to the end
                    n = (kind < 18) ? $urandom_range(span - 1) : span;
                    // long lines are cut to keep the phase near its item budget
                    if (n > ITEMS_PER_PHASE - made)
                        n = ITEMS_PER_PHASE - made;
                    queue_steps(n);
                    made += n + 1;
                    if (n == span && $urandom_range(3) == 0)
                        queue_steps($urandom_range(2, 1));
                end
            end
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/fplr_pkg.sv
hdl/fplr_div.sv
hdl/fixed_point_line_rasterizer.sv
dv/tb_fixed_point_line_rasterizer.sv
